// ----- sv/dwpsc_pkg.sv -----
// Package for the dual-wheel PID speed controller.
// Holds item structs, state codes, register indexes and datapath widths.
// No dependencies.
`default_nettype none

package dwpsc_pkg;

  // Item payloads
  typedef struct packed {
    logic signed [15:0] setpoint_left;
    logic signed [15:0] setpoint_right;
    logic signed [15:0] measured_left;
    logic signed [15:0] measured_right;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] power_left;
    logic signed [15:0] power_right;
  } out_item_t;

  // Configuration register indexes
  localparam logic [2:0] REG_POWER_OFFSET  = 3'd0;
  localparam logic [2:0] REG_FF_GAIN       = 3'd1;
  localparam logic [2:0] REG_P_GAIN        = 3'd2;
  localparam logic [2:0] REG_I_GAIN        = 3'd3;
  localparam logic [2:0] REG_D_GAIN        = 3'd4;
  localparam logic [2:0] REG_INT_LIMIT     = 3'd5;
  localparam logic [2:0] REG_TICK_INTERVAL = 3'd6;
  localparam logic [2:0] REG_TICK_DIVISOR  = 3'd7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Reset values of the conversion registers
  localparam logic [9:0]  TICK_INTERVAL_RST = 10'd20;
  localparam logic [15:0] TICK_DIVISOR_RST  = 16'd1;

  // Datapath widths
  localparam int MUL_A_W = 30;               // widest operand: proportional error
  localparam int MUL_B_W = 17;               // gains, interval zero-extended
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 49;               // sum of offset and four products
  localparam int QUO_W   = 28;               // |setpoint * 4 * interval| < 2^28
  localparam int TICK_W  = QUO_W + 1;
  localparam int PERR_W  = TICK_W + 1;
  localparam int DERR_W  = 17;
  localparam int CNT_W   = 5;

  // MAC step selects
  localparam logic [2:0] MAC_FF = 3'd0;
  localparam logic [2:0] MAC_P  = 3'd1;
  localparam logic [2:0] MAC_I  = 3'd2;
  localparam logic [2:0] MAC_D  = 3'd3;
  localparam logic [2:0] MAC_END = 3'd4;

  // Sequencer states, one-hot
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_CONV  = 9'b000000010,
    ST_DLOAD = 9'b000000100,
    ST_DIV   = 9'b000001000,
    ST_TICKS = 9'b000010000,
    ST_ERR   = 9'b000100000,
    ST_MAC   = 9'b001000000,
    ST_SAT   = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

endpackage

`default_nettype wire

// ----- sv/dual_wheel_pid_speed_control.sv -----
// Dual-wheel PID speed controller: top level and whole datapath; depends on dwpsc_pkg.
// Each wheel in turn: setpoint times interval, 28-step shift-subtract divide by the divisor,
// errors, four MAC steps on the shared 30x17 multiplier, saturate (a zero quotient skips to
// saturate). A new item is accepted only after the last result is loaded for output.
// Reset (rst_n low, synchronous): registers to defaults, integrators and previous speeds
// to zero, no result pending.
`default_nettype none

module dual_wheel_pid_speed_control (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire dwpsc_pkg::in_item_t                 in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output dwpsc_pkg::out_item_t                     out_data,
  input  wire logic                                cfg_we,
  input  wire logic [dwpsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dwpsc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int MA = dwpsc_pkg::MUL_A_W;
  localparam int MB = dwpsc_pkg::MUL_B_W;
  localparam int PW = dwpsc_pkg::PROD_W;
  localparam int AW = dwpsc_pkg::ACC_W;
  localparam int QW = dwpsc_pkg::QUO_W;
  localparam int TW = dwpsc_pkg::TICK_W;
  localparam int EW = dwpsc_pkg::PERR_W;
  localparam int DW = dwpsc_pkg::DERR_W;
  localparam int CW = dwpsc_pkg::CNT_W;

  // Configuration registers
  logic signed [15:0] off_r, kff_r, kp_r, ki_r, kd_r;
  logic [14:0]        ilim_r;
  logic [9:0]         intv_r;
  logic [15:0]        tdiv_r;

  // Sequencer and datapath registers
  dwpsc_pkg::state_t  state_r, state_nxt;
  dwpsc_pkg::in_item_t item_r;
  logic               wheel_r;
  logic [CW-1:0]      cnt_r;
  logic signed [PW-1:0] prod_r;
  logic [QW-1:0]      quo_r;
  logic [15:0]        rem_r;
  logic               neg_r;
  logic signed [TW-1:0] ticks_r;
  logic signed [EW-1:0] perr_r;
  logic signed [DW-1:0] derr_r;
  logic signed [AW-1:0] acc_r;
  logic signed [15:0] integ_r [2];
  logic signed [15:0] prev_r  [2];
  logic signed [15:0] pow_r   [2];
  dwpsc_pkg::out_item_t out_r;
  logic               out_valid_r;

  // Current wheel operands
  logic signed [15:0] sp, meas;
  assign sp   = wheel_r ? item_r.setpoint_right : item_r.setpoint_left;
  assign meas = wheel_r ? item_r.measured_right : item_r.measured_left;

  logic [15:0] div_eff;
  assign div_eff = (tdiv_r == 16'd0) ? 16'd1 : tdiv_r;

  // Shared multiplier operand select
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] mul_p;

  always_comb begin
    mul_a = {{(MA-16){sp[15]}}, sp};
    mul_b = $signed({{(MB-10){1'b0}}, intv_r});
    if (state_r == dwpsc_pkg::ST_MAC) begin
      unique case (cnt_r[2:0])
        dwpsc_pkg::MAC_FF: begin
          mul_a = {{(MA-TW){ticks_r[TW-1]}}, ticks_r};
          mul_b = {{(MB-16){kff_r[15]}}, kff_r};
        end
        dwpsc_pkg::MAC_P: begin
          mul_a = perr_r;
          mul_b = {{(MB-16){kp_r[15]}}, kp_r};
        end
        dwpsc_pkg::MAC_I: begin
          mul_a = {{(MA-16){integ_r[wheel_r][15]}}, integ_r[wheel_r]};
          mul_b = {{(MB-16){ki_r[15]}}, ki_r};
        end
        dwpsc_pkg::MAC_D: begin
          mul_a = {{(MA-DW){derr_r[DW-1]}}, derr_r};
          mul_b = {{(MB-16){kd_r[15]}}, kd_r};
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
    mul_p = mul_a * mul_b;
  end

  // Divider step: shift in next dividend bit, subtract if it fits
  logic [16:0] rem_sh, rem_sub;
  logic        q_bit;
  assign rem_sh  = {rem_r, quo_r[QW-1]};
  assign q_bit   = rem_sh >= {1'b0, div_eff};
  assign rem_sub = q_bit ? (rem_sh - {1'b0, div_eff}) : rem_sh;

  // Magnitude of the conversion product (times four when loaded into the divider)
  logic [PW-1:0] prod_mag;
  assign prod_mag = prod_r[PW-1] ? PW'(-prod_r) : PW'(prod_r);

  // Signed ticks from the quotient
  logic signed [TW-1:0] ticks_val;
  assign ticks_val = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

  // Errors and clamped integrator
  logic signed [EW-1:0] perr_val;
  logic signed [EW:0]   iacc;
  logic signed [EW:0]   ilim_pos, ilim_neg;
  logic signed [15:0]   integ_val;
  assign perr_val = {ticks_r[TW-1], ticks_r} - {{(EW-16){meas[15]}}, meas};
  assign iacc     = {{(EW+1-16){integ_r[wheel_r][15]}}, integ_r[wheel_r]}
                  + {perr_val[EW-1], perr_val};
  assign ilim_pos = $signed({{(EW+1-15){1'b0}}, ilim_r});
  assign ilim_neg = -ilim_pos;

  always_comb begin
    priority if (iacc > ilim_pos) begin
      integ_val = ilim_pos[15:0];
    end else if (iacc < ilim_neg) begin
      integ_val = ilim_neg[15:0];
    end else begin
      integ_val = iacc[15:0];
    end
  end

  // Saturate accumulated power to 16 bits
  logic signed [15:0] sat_val;
  always_comb begin
    priority if (acc_r > $signed(AW'(32767))) begin
      sat_val = 16'sh7FFF;
    end else if (acc_r < -$signed(AW'(32768))) begin
      sat_val = 16'sh8000;
    end else begin
      sat_val = acc_r[15:0];
    end
  end

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dwpsc_pkg::ST_IDLE:  if (in_valid) state_nxt = dwpsc_pkg::ST_CONV;
      dwpsc_pkg::ST_CONV:  state_nxt = dwpsc_pkg::ST_DLOAD;
      dwpsc_pkg::ST_DLOAD: state_nxt = dwpsc_pkg::ST_DIV;
      dwpsc_pkg::ST_DIV:   if (cnt_r == CW'(QW - 1)) state_nxt = dwpsc_pkg::ST_TICKS;
      dwpsc_pkg::ST_TICKS: begin
        state_nxt = (quo_r == '0) ? dwpsc_pkg::ST_SAT : dwpsc_pkg::ST_ERR;
      end
      dwpsc_pkg::ST_ERR:   state_nxt = dwpsc_pkg::ST_MAC;
      dwpsc_pkg::ST_MAC:   if (cnt_r[2:0] == dwpsc_pkg::MAC_END) state_nxt = dwpsc_pkg::ST_SAT;
      dwpsc_pkg::ST_SAT:   state_nxt = wheel_r ? dwpsc_pkg::ST_DONE : dwpsc_pkg::ST_CONV;
      dwpsc_pkg::ST_DONE:  if (out_free) state_nxt = dwpsc_pkg::ST_IDLE;
      default:             state_nxt = dwpsc_pkg::ST_IDLE;
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dwpsc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      off_r  <= '0;
      kff_r  <= '0;
      kp_r   <= '0;
      ki_r   <= '0;
      kd_r   <= '0;
      ilim_r <= '0;
      intv_r <= dwpsc_pkg::TICK_INTERVAL_RST;
      tdiv_r <= dwpsc_pkg::TICK_DIVISOR_RST;
      integ_r[0] <= '0;
      integ_r[1] <= '0;
      prev_r[0]  <= '0;
      prev_r[1]  <= '0;
    end else begin
      state_r <= state_nxt;
      // Hold the result until taken; load when the last wheel is done
      if (state_r == dwpsc_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          dwpsc_pkg::REG_POWER_OFFSET:  off_r  <= $signed(cfg_wdata);
          dwpsc_pkg::REG_FF_GAIN:       kff_r  <= $signed(cfg_wdata);
          dwpsc_pkg::REG_P_GAIN:        kp_r   <= $signed(cfg_wdata);
          dwpsc_pkg::REG_I_GAIN:        ki_r   <= $signed(cfg_wdata);
          dwpsc_pkg::REG_D_GAIN:        kd_r   <= $signed(cfg_wdata);
          dwpsc_pkg::REG_INT_LIMIT:     ilim_r <= cfg_wdata[14:0];
          dwpsc_pkg::REG_TICK_INTERVAL: intv_r <= cfg_wdata[9:0];
          dwpsc_pkg::REG_TICK_DIVISOR:  tdiv_r <= cfg_wdata;
          default: ;
        endcase
      end
      // Clear integrator on zero ticks; update wheel state otherwise
      if (state_r == dwpsc_pkg::ST_TICKS && quo_r == '0) begin
        integ_r[wheel_r] <= '0;
      end
      if (state_r == dwpsc_pkg::ST_ERR) begin
        integ_r[wheel_r] <= integ_val;
        prev_r[wheel_r]  <= meas;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      dwpsc_pkg::ST_IDLE: begin
        item_r  <= in_data;
        wheel_r <= 1'b0;
      end
      dwpsc_pkg::ST_CONV: begin
        prod_r <= mul_p;
      end
      dwpsc_pkg::ST_DLOAD: begin
        neg_r <= prod_r[PW-1];
        quo_r <= {prod_mag[QW-3:0], 2'b00};
        rem_r <= '0;
        cnt_r <= '0;
      end
      dwpsc_pkg::ST_DIV: begin
        quo_r <= {quo_r[QW-2:0], q_bit};
        rem_r <= rem_sub[15:0];
        cnt_r <= cnt_r + CW'(1);
      end
      dwpsc_pkg::ST_TICKS: begin
        ticks_r <= ticks_val;
        acc_r   <= '0;
      end
      dwpsc_pkg::ST_ERR: begin
        perr_r <= perr_val;
        derr_r <= {meas[15], meas} - {prev_r[wheel_r][15], prev_r[wheel_r]};
        acc_r  <= {{(AW-16){off_r[15]}}, off_r};
        cnt_r  <= '0;
      end
      dwpsc_pkg::ST_MAC: begin
        // Product of step n is added during step n+1
        prod_r <= mul_p;
        if (cnt_r[2:0] != dwpsc_pkg::MAC_FF) begin
          acc_r <= acc_r + {{(AW-PW){prod_r[PW-1]}}, prod_r};
        end
        cnt_r <= cnt_r + CW'(1);
      end
      dwpsc_pkg::ST_SAT: begin
        pow_r[wheel_r] <= sat_val;
        wheel_r        <= 1'b1;
      end
      dwpsc_pkg::ST_DONE: begin
        if (out_free) begin
          out_r.power_left  <= pow_r[0];
          out_r.power_right <= pow_r[1];
        end
      end
      default: ;
    endcase
  end

  // Accept an item only when idle and out of reset
  assign in_ready  = rst_n && (state_r == dwpsc_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire
